// ===== hw/rtl/esc_pkg.sv =====
// esc_pkg: shared types, widths and constants of the engine sensor conditioner
// no dependencies; imported by the interfaces, the multiplier and the top level

package esc_pkg;

	// default depth of the pressure moving average
	localparam int AVERAGE_DEPTH_DEF = 16;
	// channels at or above this count are ignored
	localparam int CHANNEL_COUNT     = 7;

	// item and result field widths
	localparam int CHAN_W  = 4;
	localparam int CODE_W  = 12;
	localparam int VALUE_W = 17;
	localparam int COUNT_W = 32;

	// item action codes
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_TICK   = 1'b1;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int ALPHA_W    = 16;
	localparam int HALF_W     = 32;

	localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_ALPHA    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEMPERATURE_ALPHA = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_RANGE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_RANGE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COOLANT_RANGE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INTAKE_RANGE      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OXYGEN_RANGE      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BATTERY_RANGE     = 3'd7;

	localparam logic [ALPHA_W-1:0]    ALPHA_RESET = 16'd3277;
	// spare input: min 0.0, max 5.0 in Q16.16
	localparam logic [CFG_DATA_W-1:0] SPARE_RANGE = 64'h0005_0000_0000_0000;

	// channel codes
	localparam logic [CHAN_W-1:0] CH_PRESSURE = 4'd0;
	localparam logic [CHAN_W-1:0] CH_THROTTLE = 4'd1;
	localparam logic [CHAN_W-1:0] CH_COOLANT  = 4'd2;
	localparam logic [CHAN_W-1:0] CH_INTAKE   = 4'd3;
	localparam logic [CHAN_W-1:0] CH_OXYGEN   = 4'd4;
	localparam logic [CHAN_W-1:0] CH_BATTERY  = 4'd5;
	localparam logic [CHAN_W-1:0] CH_SPARE    = 4'd6;

	// exponential filter state, Q12.16
	localparam int STATE_W = 28;
	localparam int FRAC_W  = 16;

	// shared multiplier operands and product
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 30;
	localparam int MUL_P_W = 64;

	// scaling datapath
	localparam int BASE_W = 47;
	localparam int NUM_W  = 57;
	localparam int X_W    = 28;
	localparam int Q_W    = 16;
	// 4095 * 65536: magnitudes at or above this saturate
	localparam logic [X_W-1:0] X_LIMIT  = 28'd268369920;
	// ceil(2^40 / 4095) and its shift, exact for 28-bit dividends
	localparam logic [MUL_B_W-1:0] RECIP_FS = 30'd268501009;
	localparam int RECIP_SH = 40;
	localparam logic [Q_W-1:0]     NEG_LIMIT = 16'd32768;
	// -32768 in the 17-bit signed result
	localparam logic [VALUE_W-1:0] VALUE_MIN = 17'h18000;

	typedef enum logic [1:0] {
		K_ONE,
		K_TEN,
		K_THOUSAND
	} kfac_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AVG,
		ST_AVG_MUL,
		ST_AVG_CODE,
		ST_EMA_MUL,
		ST_EMA_UPD,
		ST_SPAN_MUL,
		ST_BASE,
		ST_NUM,
		ST_ABS,
		ST_Q_MUL,
		ST_FIN,
		ST_OUT
	} st_t;

endpackage

// ===== hw/rtl/esc_in_if.sv =====
// esc_in_if: valid/ready channel carrying one sample or batch-end item
// depends on esc_pkg for field widths

interface esc_in_if;
	logic                       valid;
	logic                       ready;
	logic                       action;
	logic [esc_pkg::CHAN_W-1:0] channel;
	logic [esc_pkg::CODE_W-1:0] sample;

	modport source (output valid, output action, output channel, output sample, input ready);
	modport sink (input valid, input action, input channel, input sample, output ready);
endinterface

// ===== hw/rtl/esc_out_if.sv =====
// esc_out_if: valid/ready channel carrying one conditioned result item
// depends on esc_pkg for field widths

interface esc_out_if;
	logic                               valid;
	logic                               ready;
	logic [esc_pkg::CHAN_W-1:0]         channel_out;
	logic [esc_pkg::CODE_W-1:0]         raw_code;
	logic signed [esc_pkg::VALUE_W-1:0] value;
	logic                               updated;
	logic [esc_pkg::COUNT_W-1:0]        batch_count;

	modport source (output valid, output channel_out, output raw_code, output value,
		output updated, output batch_count, input ready);
	modport sink (input valid, input channel_out, input raw_code, input value,
		input updated, input batch_count, output ready);
endinterface

// ===== hw/rtl/esc_ram.sv =====
// esc_ram: generic single-write, single-read memory with registered read data
// no dependencies

module esc_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== hw/rtl/esc_mul.sv =====
// esc_mul: shared signed multiplier with registered product
// depends on esc_pkg for operand and product widths

module esc_mul (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [esc_pkg::MUL_A_W-1:0] a,
	input  logic signed [esc_pkg::MUL_B_W-1:0] b,
	output logic signed [esc_pkg::MUL_P_W-1:0] p
);
	import esc_pkg::*;

	logic signed [MUL_P_W-1:0] a_ext;
	logic signed [MUL_P_W-1:0] b_ext;
	logic signed [MUL_P_W-1:0] p_q;

	assign a_ext = {{(MUL_P_W-MUL_A_W){a[MUL_A_W-1]}}, a};
	assign b_ext = {{(MUL_P_W-MUL_B_W){b[MUL_B_W-1]}}, b};

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a_ext * b_ext;
		end
	end

	assign p = p_q;
endmodule

// ===== hw/rtl/engine_sensor_conditioner.sv =====
// engine_sensor_conditioner: top level, sequencer around one shared multiplier
// ticks and pass-through items go straight to the output step; oxygen/battery/spare
// run the span and reciprocal passes, the exponential filters a filter pass first,
// pressure an average pass first; a new item is taken only after the last is loaded
// async reset: alphas 3277, ranges, filters, average flags, sum and pointer, counters zero
// depends on esc_pkg, esc_in_if, esc_out_if, esc_ram, esc_mul

module engine_sensor_conditioner #(
	parameter int AVERAGE_DEPTH = esc_pkg::AVERAGE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [esc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [esc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	esc_in_if.sink                           sample_ch,
	esc_out_if.source                        result_ch
);
	import esc_pkg::*;

	// moving average geometry
	localparam int PTR_W   = $clog2(AVERAGE_DEPTH);
	localparam int SUM_MAX = AVERAGE_DEPTH * 4095;
	localparam int SUM_W   = $clog2(SUM_MAX + 1);
	// sum / depth as a multiply by ceil(2^(SUM_W+PTR_W) / depth) and a shift
	localparam int AVG_SH  = SUM_W + PTR_W;
	localparam logic [63:0] AVG_RECIP =
		((64'd1 << AVG_SH) + 64'(AVERAGE_DEPTH) - 64'd1) / 64'(AVERAGE_DEPTH);

	// configuration registers
	logic [ALPHA_W-1:0]    thr_alpha_q;
	logic [ALPHA_W-1:0]    tmp_alpha_q;
	logic [CFG_DATA_W-1:0] pres_rng_q;
	logic [CFG_DATA_W-1:0] thr_rng_q;
	logic [CFG_DATA_W-1:0] cool_rng_q;
	logic [CFG_DATA_W-1:0] intk_rng_q;
	logic [CFG_DATA_W-1:0] oxy_rng_q;
	logic [CFG_DATA_W-1:0] batt_rng_q;

	// filter and counter state
	logic [AVERAGE_DEPTH-1:0] avg_valid_q;
	logic [PTR_W-1:0]         ptr_q;
	logic [SUM_W-1:0]         avg_sum_q;
	logic [STATE_W-1:0]       thr_st_q;
	logic [STATE_W-1:0]       cool_st_q;
	logic [STATE_W-1:0]       intk_st_q;
	logic [1:0]               phase_q;
	logic [COUNT_W-1:0]       batch_q;

	// sequencer
	st_t state_q;
	st_t state_d;

	// per-item working registers
	logic [CHAN_W-1:0]         chan_q;
	logic [CODE_W-1:0]         sample_q;
	logic [CODE_W-1:0]         raw_q;
	logic [CODE_W-1:0]         code_q;
	logic [ALPHA_W-1:0]        alpha_q;
	logic signed [STATE_W:0]   diff_q;
	logic signed [HALF_W-1:0]  lo_q;
	logic signed [HALF_W:0]    span_q;
	logic                      ordered_q;
	kfac_t                     ksel_q;
	logic signed [BASE_W-1:0]  base_q;
	logic signed [NUM_W-1:0]   num_q;
	logic [X_W-1:0]            x_q;
	logic                      neg_q;
	logic signed [VALUE_W-1:0] value_q;
	logic                      updated_q;

	// output register
	logic                      out_valid_q;
	logic [CHAN_W-1:0]         out_chan_q;
	logic [CODE_W-1:0]         out_raw_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic                      out_upd_q;
	logic [COUNT_W-1:0]        out_batch_q;

	// shared multiplier
	logic                      mul_en;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod;

	// average store
	logic              ram_we;
	logic [CODE_W-1:0] ram_rdata;

	logic accept;
	logic out_load;
	logic dec_open;
	logic chan_dropped;

	// combinational datapath values
	logic [CFG_DATA_W-1:0]    rng_sel;
	logic signed [HALF_W-1:0] rng_lo;
	logic signed [HALF_W-1:0] rng_hi;
	kfac_t                    kfac_sel;
	logic [STATE_W-1:0]       ema_in;
	logic [STATE_W-1:0]       ema_old;
	logic [STATE_W-1:0]       ema_new;
	logic [CODE_W-1:0]        avg_old;
	logic [SUM_W-1:0]         avg_sum_new;
	logic signed [NUM_W-1:0]  num_ext;
	logic signed [NUM_W-1:0]  num_new;
	logic [NUM_W-1:0]         num_mag;
	logic [NUM_W-FRAC_W-1:0]  x_wide;
	logic [Q_W-1:0]           quot;

	assign accept       = sample_ch.valid && sample_ch.ready;
	assign sample_ch.ready = (state_q == ST_IDLE);
	// coolant through spare only run while the batch phase is zero
	assign dec_open     = (phase_q == 2'd0);
	assign chan_dropped = ({1'b0, sample_ch.channel} >= (CHAN_W + 1)'(CHANNEL_COUNT));

	// ---------------------------------------------------------------------
	// configuration writes
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_alpha_q <= ALPHA_RESET;
			tmp_alpha_q <= ALPHA_RESET;
			pres_rng_q  <= '0;
			thr_rng_q   <= '0;
			cool_rng_q  <= '0;
			intk_rng_q  <= '0;
			oxy_rng_q   <= '0;
			batt_rng_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_THROTTLE_ALPHA:    thr_alpha_q <= cfg_wdata[ALPHA_W-1:0];
				REG_TEMPERATURE_ALPHA: tmp_alpha_q <= cfg_wdata[ALPHA_W-1:0];
				REG_PRESSURE_RANGE:    pres_rng_q  <= cfg_wdata;
				REG_THROTTLE_RANGE:    thr_rng_q   <= cfg_wdata;
				REG_COOLANT_RANGE:     cool_rng_q  <= cfg_wdata;
				REG_INTAKE_RANGE:      intk_rng_q  <= cfg_wdata;
				REG_OXYGEN_RANGE:      oxy_rng_q   <= cfg_wdata;
				REG_BATTERY_RANGE:     batt_rng_q  <= cfg_wdata;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// per-channel selection at accept: range, unit factor, filter state
	// ---------------------------------------------------------------------
	always_comb begin
		rng_sel  = '0;
		kfac_sel = K_ONE;
		ema_in   = intk_st_q;
		unique case (sample_ch.channel) inside
			CH_PRESSURE: begin
				rng_sel  = pres_rng_q;
				kfac_sel = K_TEN;
			end
			CH_THROTTLE: begin
				rng_sel = thr_rng_q;
				ema_in  = thr_st_q;
			end
			CH_COOLANT: begin
				rng_sel = cool_rng_q;
				ema_in  = cool_st_q;
			end
			CH_INTAKE: rng_sel = intk_rng_q;
			CH_OXYGEN: begin
				rng_sel  = oxy_rng_q;
				kfac_sel = K_THOUSAND;
			end
			CH_BATTERY: begin
				rng_sel  = batt_rng_q;
				kfac_sel = K_TEN;
			end
			CH_SPARE: begin
				rng_sel  = SPARE_RANGE;
				kfac_sel = K_THOUSAND;
			end
			default: rng_sel = '0;
		endcase
	end

	assign rng_lo = rng_sel[HALF_W-1:0];
	assign rng_hi = rng_sel[CFG_DATA_W-1:HALF_W];

	// ---------------------------------------------------------------------
	// sequencer: state register and next state
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		mul_en   = 1'b0;
		ram_we   = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (sample_ch.action || chan_dropped) begin
						state_d = ST_OUT;
					end else begin
						case (sample_ch.channel) inside
							CH_PRESSURE: state_d = ST_AVG;
							CH_THROTTLE: state_d = ST_EMA_MUL;
							CH_COOLANT, CH_INTAKE:
								state_d = dec_open ? ST_EMA_MUL : ST_OUT;
							CH_OXYGEN, CH_BATTERY, CH_SPARE:
								state_d = dec_open ? ST_SPAN_MUL : ST_OUT;
							default: state_d = ST_OUT;
						endcase
					end
				end
			end
			ST_AVG: begin
				ram_we  = 1'b1;
				state_d = ST_AVG_MUL;
			end
			ST_AVG_MUL: begin
				mul_en  = 1'b1;
				state_d = ST_AVG_CODE;
			end
			ST_AVG_CODE: state_d = ST_SPAN_MUL;
			ST_EMA_MUL: begin
				mul_en  = 1'b1;
				state_d = ST_EMA_UPD;
			end
			ST_EMA_UPD: state_d = ST_SPAN_MUL;
			ST_SPAN_MUL: begin
				mul_en  = 1'b1;
				state_d = ST_BASE;
			end
			ST_BASE: state_d = ST_NUM;
			ST_NUM:  state_d = ST_ABS;
			ST_ABS:  state_d = ST_Q_MUL;
			ST_Q_MUL: begin
				mul_en  = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: state_d = ST_OUT;
			ST_OUT: begin
				// wait here while the previous result still sits unclaimed
				if (!out_valid_q || result_ch.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------------
	// shared multiplier: operand selection by step
	// ---------------------------------------------------------------------
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			// running sum times reciprocal of the depth
			ST_AVG_MUL: begin
				mul_a = MUL_A_W'(avg_sum_q);
				mul_b = MUL_B_W'(AVG_RECIP);
			end
			// alpha times (new sample - state)
			ST_EMA_MUL: begin
				mul_a = MUL_A_W'(diff_q);
				mul_b = MUL_B_W'(alpha_q);
			end
			// (max - min) times code, code forced to zero on an empty range
			ST_SPAN_MUL: begin
				mul_a = MUL_A_W'(span_q);
				mul_b = ordered_q ? MUL_B_W'(code_q) : '0;
			end
			// magnitude times reciprocal of 4095
			ST_Q_MUL: begin
				mul_a = MUL_A_W'(x_q);
				mul_b = RECIP_FS;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	esc_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// ---------------------------------------------------------------------
	// moving average store, read always at the pointer
	// ---------------------------------------------------------------------
	esc_ram #(
		.WIDTH (CODE_W),
		.DEPTH (AVERAGE_DEPTH)
	) u_avg_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ptr_q),
		.wdata (sample_q),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	// never-written entries read as zero
	assign avg_old     = avg_valid_q[ptr_q] ? ram_rdata : '0;
	assign avg_sum_new = avg_sum_q - SUM_W'(avg_old) + SUM_W'(sample_q);

	// exponential filter: s + floor(alpha * (S - s) / 2^16)
	always_comb begin
		case (chan_q)
			CH_THROTTLE: ema_old = thr_st_q;
			CH_COOLANT:  ema_old = cool_st_q;
			default:     ema_old = intk_st_q;
		endcase
	end
	assign ema_new = ema_old + prod[FRAC_W +: STATE_W];

	// unit factor by shift and add
	assign num_ext = NUM_W'(base_q);
	always_comb begin
		case (ksel_q)
			K_TEN:      num_new = (num_ext <<< 3) + (num_ext <<< 1);
			K_THOUSAND: num_new = (num_ext <<< 10) - (num_ext <<< 4) - (num_ext <<< 3);
			default:    num_new = num_ext;
		endcase
	end

	// magnitude over 2^16, clamped just below the saturation point
	assign num_mag = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
	assign x_wide  = num_mag[NUM_W-1:FRAC_W];
	assign quot    = prod[RECIP_SH +: Q_W];

	// ---------------------------------------------------------------------
	// filter state, average state and counters
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_valid_q <= '0;
			ptr_q       <= '0;
			avg_sum_q   <= '0;
			thr_st_q    <= '0;
			cool_st_q   <= '0;
			intk_st_q   <= '0;
			phase_q     <= '0;
			batch_q     <= '0;
		end else begin
			if (accept && sample_ch.action) begin
				batch_q <= batch_q + COUNT_W'(1);
				phase_q <= phase_q + 2'd1;
			end
			if (state_q == ST_AVG) begin
				avg_sum_q          <= avg_sum_new;
				avg_valid_q[ptr_q] <= 1'b1;
				ptr_q <= (ptr_q == PTR_W'(AVERAGE_DEPTH - 1)) ? '0 : ptr_q + PTR_W'(1);
			end
			if (state_q == ST_EMA_UPD) begin
				case (chan_q)
					CH_THROTTLE: thr_st_q  <= ema_new;
					CH_COOLANT:  cool_st_q <= ema_new;
					default:     intk_st_q <= ema_new;
				endcase
			end
		end
	end

	// ---------------------------------------------------------------------
	// per-item datapath registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			// batch ticks report channel zero; dropped channels echo no code
			chan_q    <= sample_ch.action ? CH_PRESSURE : sample_ch.channel;
			raw_q     <= (sample_ch.action || chan_dropped) ? '0 : sample_ch.sample;
			sample_q  <= sample_ch.sample;
			code_q    <= sample_ch.sample;
			value_q   <= '0;
			updated_q <= 1'b0;
			alpha_q   <= (sample_ch.channel == CH_THROTTLE) ? thr_alpha_q : tmp_alpha_q;
			diff_q    <= $signed({1'b0, sample_ch.sample, {FRAC_W{1'b0}}})
				- $signed({1'b0, ema_in});
			lo_q      <= rng_lo;
			span_q    <= (HALF_W + 1)'(rng_hi) - (HALF_W + 1)'(rng_lo);
			ordered_q <= (rng_hi > rng_lo);
			ksel_q    <= kfac_sel;
		end
		case (state_q)
			ST_AVG_CODE: code_q <= prod[AVG_SH +: CODE_W];
			ST_EMA_UPD:  code_q <= ema_new[STATE_W-1:FRAC_W];
			// min * 4095 + span * code
			ST_BASE: base_q <= (BASE_W'(lo_q) <<< 12) - BASE_W'(lo_q) + prod[BASE_W-1:0];
			ST_NUM:  num_q  <= num_new;
			ST_ABS: begin
				neg_q <= num_q[NUM_W-1];
				x_q   <= (x_wide >= (NUM_W - FRAC_W)'(X_LIMIT)) ? X_LIMIT - X_W'(1)
					: x_wide[X_W-1:0];
			end
			ST_FIN: begin
				updated_q <= 1'b1;
				if (!neg_q) begin
					value_q <= VALUE_W'(quot);
				end else if (quot > NEG_LIMIT) begin
					value_q <= VALUE_MIN;
				end else begin
					value_q <= VALUE_W'(0) - VALUE_W'(quot);
				end
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------------
	// output register: holds one finished item while the next is taken
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_chan_q  <= chan_q;
			out_raw_q   <= raw_q;
			out_value_q <= value_q;
			out_upd_q   <= updated_q;
			out_batch_q <= batch_q;
		end
	end

	assign result_ch.valid       = out_valid_q;
	assign result_ch.channel_out = out_chan_q;
	assign result_ch.raw_code    = out_raw_q;
	assign result_ch.value       = out_value_q;
	assign result_ch.updated     = out_upd_q;
	assign result_ch.batch_count = out_batch_q;

	// ---------------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------------
	// pointer wraps before the end of the store, also for odd depths
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= PTR_W'(AVERAGE_DEPTH - 1))
		else $error("average pointer beyond store depth");

	// running sum never exceeds a full store of full-scale codes
	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		avg_sum_q <= SUM_W'(SUM_MAX))
		else $error("running sum out of range");

	// a batch tick advances the counter by exactly one
	a_batch_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && sample_ch.action) |=> (batch_q == $past(batch_q) + COUNT_W'(1)))
		else $error("batch counter did not advance");

	// only processed channels report a recomputed value
	a_upd_chan: assert property (@(posedge clk) disable iff (!arst_n)
		(result_ch.valid && result_ch.updated) |-> (result_ch.channel_out <= CH_SPARE))
		else $error("updated result on a channel without processing");

endmodule
